### design/nrmc_pkg.sv
// nrmc_pkg: shared types, character codes and calendar constants for the
// RMC sentence parser. No dependencies.
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // header match progress: 0..5 chars matched so far, then match or fail
  localparam logic [2:0] HDR_MATCH = 3'd6;
  localparam logic [2:0] HDR_FAIL  = 3'd7;

  localparam logic [3:0] FLD_TIME  = 4'd1;
  localparam logic [3:0] FLD_LAT   = 4'd3;
  localparam logic [3:0] FLD_LON   = 4'd5;
  localparam logic [3:0] FLD_SPEED = 4'd7;
  localparam logic [3:0] FLD_DATE  = 4'd9;
  localparam logic [3:0] FLD_MAX   = 4'd15;
  localparam logic [3:0] CNT_MAX   = 4'd15;

  localparam logic [3:0] NIB_DOT   = 4'd10;
  localparam logic [3:0] NIB_OTHER = 4'd11;

  localparam logic [29:0] SPEED_MAX = 30'd999999999;
  localparam logic [43:0] LAT_EMPTY = 44'hFFF_FFFF_FFFF;
  localparam logic [47:0] LON_EMPTY = 48'hFFFF_FFFF_FFFF;
  localparam logic [43:0] LAT_RESET = {4'h0, 40'hFF_FFFF_FFFF};
  localparam logic [47:0] LON_RESET = {4'h0, 44'hFFF_FFFF_FFFF};

  localparam logic [4:0] UTC_OFFSET_RESET = 5'd8;
  localparam logic [4:0] HOUR_MAX         = 5'd23;
  localparam logic [6:0] HOURS_PER_DAY    = 7'd24;
  localparam logic [6:0] MONTHS_PER_YEAR  = 7'd12;
  localparam logic [6:0] YEAR_MAX         = 7'd99;
  localparam logic [6:0] MIN_SEC_MAX      = 7'd59;
  localparam logic [6:0] DAY_MAX          = 7'd31;
  localparam logic [6:0] FEB_LEAP_DAYS    = 7'd29;

  typedef enum logic [2:0] {
    SPD_IDLE  = 3'd0,
    SPD_INT   = 3'd1,
    SPD_FRAC0 = 3'd2,
    SPD_FRAC1 = 3'd3,
    SPD_FRAC2 = 3'd4,
    SPD_DONE  = 3'd5,
    SPD_DOT   = 3'd6,
    SPD_STOP  = 3'd7
  } spd_mode_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic [4:0] utc_offset_hours;
  } cfg_word_t;

  typedef struct packed {
    logic [6:0]  local_year;
    logic [3:0]  local_month;
    logic [4:0]  local_day;
    logic [4:0]  local_hour;
    logic [5:0]  local_minute;
    logic [5:0]  local_second;
    logic [29:0] speed_milliknots;
    logic [43:0] latitude_text;
    logic [47:0] longitude_text;
    logic        line_truncated;
  } res_word_t;

  // line snapshot handed from the parser to the calendar stage
  typedef struct packed {
    logic [23:0] time_cap;
    logic [23:0] date_cap;
    logic [29:0] speed;
    logic [43:0] lat;
    logic [47:0] lon;
    logic        trunc;
  } snap_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h24;  // $
      3'd1:    return 8'h47;  // G
      3'd2:    return 8'h50;  // P
      3'd3:    return 8'h52;  // R
      3'd4:    return 8'h4D;  // M
      3'd5:    return 8'h43;  // C
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [6:0] month_len(input logic [3:0] idx);
    case (idx)
      4'd1:                 return 7'd28;
      4'd3, 4'd5, 4'd8, 4'd10: return 7'd30;
      default:              return 7'd31;
    endcase
  endfunction

endpackage

### design/nrmc_if.sv
// nrmc_if: valid/ready channel interfaces for received bytes, results and
// the offset register write. Depends on nrmc_pkg.
`timescale 1ns / 1ps

interface nrmc_rx_if import nrmc_pkg::*; ();
  logic     valid;
  logic     ready;
  rx_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrmc_res_if import nrmc_pkg::*; ();
  logic      valid;
  logic      ready;
  res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrmc_cfg_if import nrmc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/nrmc_parse.sv
// nrmc_parse: input byte register, per-line parse state and the line
// snapshot register loaded at each RMC newline. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_parse import nrmc_pkg::*; #(
  parameter int MAX_LINE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  output logic       snap_valid,
  input  logic       snap_ready,
  output snap_t      snap
);

  localparam int LW = $clog2(MAX_LINE + 1);

  logic [7:0]    byte_q;
  logic          byte_v;
  logic          consume;

  logic [2:0]    header_progress, header_progress_next;
  logic          line_is_rmc, line_is_rmc_next;
  logic [LW-1:0] line_length, line_length_next;
  logic [3:0]    field_number, field_number_next;
  logic [3:0]    field_char_count, field_char_count_next;
  logic [23:0]   time_capture, time_capture_next;
  logic [23:0]   date_capture, date_capture_next;
  logic [29:0]   speed_acc, speed_acc_next;
  spd_mode_t     spd_mode, spd_mode_next;
  logic [43:0]   lat_shift, lat_shift_next;
  logic [47:0]   lon_shift, lon_shift_next;
  logic [43:0]   stored_lat, stored_lat_next;
  logic [47:0]   stored_lon, stored_lon_next;
  logic [29:0]   stored_speed, stored_speed_next;
  logic          overflow_seen, overflow_seen_next;
  logic          snap_load;
  snap_t         snap_next;

  logic          is_dig;
  logic [3:0]    dig_val;
  logic [3:0]    text_nib;
  logic [3:0]    cap_nib;
  logic [29:0]   acc_push;
  logic [9:0]    end_scale;
  logic [29:0]   acc_scaled;
  logic [9:0]    commit_scale;
  logic          commit_en;
  logic [29:0]   acc_commit;

  function automatic logic [29:0] sat30(input logic [39:0] v);
    return (v > 40'(SPEED_MAX)) ? SPEED_MAX : v[29:0];
  endfunction

  assign consume    = byte_v && (!snap_valid || snap_ready);
  assign byte_ready = !byte_v || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_v <= 1'b0;
    end else if (byte_ready) begin
      byte_v <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      byte_q <= byte_in;
    end
  end

  // character classes and arithmetic shared by the step logic
  assign is_dig   = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign dig_val  = is_dig ? 4'(byte_q - CHAR_ZERO) : 4'd0;
  assign text_nib = is_dig ? dig_val : ((byte_q == CHAR_DOT) ? NIB_DOT : NIB_OTHER);
  assign cap_nib  = is_dig ? 4'(dig_val + 4'd1) : 4'd0;
  assign acc_push = sat30(40'(speed_acc) * 40'd10 + 40'(dig_val));

  always_comb begin
    case (spd_mode)
      SPD_INT, SPD_FRAC0: end_scale = 10'd1000;
      SPD_FRAC1:          end_scale = 10'd100;
      default:            end_scale = 10'd10;
    endcase
  end
  assign acc_scaled = sat30(40'(speed_acc) * 40'(end_scale));

  always_comb begin
    commit_en = 1'b1;
    case (spd_mode)
      SPD_INT, SPD_FRAC0: commit_scale = 10'd1000;
      SPD_FRAC1:          commit_scale = 10'd100;
      SPD_FRAC2:          commit_scale = 10'd10;
      SPD_DONE:           commit_scale = 10'd1;
      default: begin
        commit_scale = 10'd1;
        commit_en    = 1'b0;
      end
    endcase
  end
  assign acc_commit = sat30(40'(speed_acc) * 40'(commit_scale));

  always_comb begin
    header_progress_next  = header_progress;
    line_is_rmc_next      = line_is_rmc;
    line_length_next      = line_length;
    field_number_next     = field_number;
    field_char_count_next = field_char_count;
    time_capture_next     = time_capture;
    date_capture_next     = date_capture;
    speed_acc_next        = speed_acc;
    spd_mode_next         = spd_mode;
    lat_shift_next        = lat_shift;
    lon_shift_next        = lon_shift;
    stored_lat_next       = stored_lat;
    stored_lon_next       = stored_lon;
    stored_speed_next     = stored_speed;
    overflow_seen_next    = overflow_seen;
    snap_load             = 1'b0;
    snap_next.time_cap    = (field_number >= 4'd2) ? time_capture : 24'd0;
    snap_next.date_cap    = (field_number >= 4'd10) ? date_capture : 24'd0;
    snap_next.speed       = stored_speed;
    snap_next.lat         = stored_lat;
    snap_next.lon         = stored_lon;
    snap_next.trunc       = overflow_seen;

    if (consume) begin
      if (byte_q == CHAR_NL) begin
        snap_load             = line_is_rmc;
        header_progress_next  = 3'd0;
        line_is_rmc_next      = 1'b0;
        line_length_next      = '0;
        field_number_next     = 4'd0;
        field_char_count_next = 4'd0;
        time_capture_next     = 24'd0;
        date_capture_next     = 24'd0;
        speed_acc_next        = 30'd0;
        spd_mode_next         = SPD_IDLE;
        lat_shift_next        = LAT_EMPTY;
        lon_shift_next        = LON_EMPTY;
        overflow_seen_next    = 1'b0;
      end else if (line_length >= LW'(MAX_LINE)) begin
        overflow_seen_next = 1'b1;
      end else begin
        line_length_next = line_length + 1'b1;
        if (header_progress < HDR_MATCH) begin
          if (byte_q == hdr_char(header_progress)) begin
            header_progress_next = header_progress + 3'd1;
          end else begin
            header_progress_next = HDR_FAIL;
          end
          if (header_progress_next == HDR_MATCH) begin
            line_is_rmc_next = 1'b1;
          end
        end

        if (byte_q == CHAR_COMMA) begin
          if (line_is_rmc_next) begin
            if (field_number == FLD_LAT && field_char_count != 4'd0) begin
              stored_lat_next = lat_shift;
            end else if (field_number == FLD_LON && field_char_count != 4'd0) begin
              stored_lon_next = lon_shift;
            end else if (field_number == FLD_SPEED && commit_en) begin
              stored_speed_next = acc_commit;
            end
          end
          if (field_number < FLD_MAX) begin
            field_number_next = field_number + 4'd1;
          end
          field_char_count_next = 4'd0;
          speed_acc_next        = 30'd0;
          spd_mode_next         = SPD_IDLE;
          lat_shift_next        = LAT_EMPTY;
          lon_shift_next        = LON_EMPTY;
        end else begin
          case (field_number)
            FLD_TIME: begin
              for (int i = 0; i < 6; i++) begin
                if (field_char_count == 4'(5 - i)) begin
                  time_capture_next[4*i +: 4] = cap_nib;
                end
              end
            end
            FLD_DATE: begin
              for (int i = 0; i < 6; i++) begin
                if (field_char_count == 4'(5 - i)) begin
                  date_capture_next[4*i +: 4] = cap_nib;
                end
              end
            end
            FLD_LAT: begin
              for (int i = 0; i < 11; i++) begin
                if (field_char_count == 4'(10 - i)) begin
                  lat_shift_next[4*i +: 4] = text_nib;
                end
              end
            end
            FLD_LON: begin
              for (int i = 0; i < 12; i++) begin
                if (field_char_count == 4'(11 - i)) begin
                  lon_shift_next[4*i +: 4] = text_nib;
                end
              end
            end
            FLD_SPEED: begin
              case (spd_mode)
                SPD_IDLE: begin
                  if (is_dig) begin
                    speed_acc_next = 30'(dig_val);
                    spd_mode_next  = SPD_INT;
                  end else if (byte_q == CHAR_DOT) begin
                    spd_mode_next = SPD_DOT;
                  end else begin
                    spd_mode_next = SPD_STOP;
                  end
                end
                SPD_INT: begin
                  if (is_dig) begin
                    speed_acc_next = acc_push;
                  end else if (byte_q == CHAR_DOT) begin
                    spd_mode_next = SPD_FRAC0;
                  end else begin
                    speed_acc_next = acc_scaled;
                    spd_mode_next  = SPD_DONE;
                  end
                end
                SPD_FRAC0, SPD_FRAC1, SPD_FRAC2: begin
                  if (is_dig) begin
                    speed_acc_next = acc_push;
                    spd_mode_next  = spd_mode_t'(spd_mode + 3'd1);
                  end else begin
                    speed_acc_next = acc_scaled;
                    spd_mode_next  = SPD_DONE;
                  end
                end
                SPD_DOT: begin
                  if (is_dig) begin
                    speed_acc_next = 30'(dig_val);
                    spd_mode_next  = SPD_FRAC1;
                  end else begin
                    spd_mode_next = SPD_STOP;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          if (field_char_count < CNT_MAX) begin
            field_char_count_next = field_char_count + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_progress  <= 3'd0;
      line_is_rmc      <= 1'b0;
      line_length      <= '0;
      field_number     <= 4'd0;
      field_char_count <= 4'd0;
      time_capture     <= 24'd0;
      date_capture     <= 24'd0;
      speed_acc        <= 30'd0;
      spd_mode         <= SPD_IDLE;
      lat_shift        <= LAT_EMPTY;
      lon_shift        <= LON_EMPTY;
      stored_lat       <= LAT_RESET;
      stored_lon       <= LON_RESET;
      stored_speed     <= 30'd0;
      overflow_seen    <= 1'b0;
      snap_valid       <= 1'b0;
    end else begin
      header_progress  <= header_progress_next;
      line_is_rmc      <= line_is_rmc_next;
      line_length      <= line_length_next;
      field_number     <= field_number_next;
      field_char_count <= field_char_count_next;
      time_capture     <= time_capture_next;
      date_capture     <= date_capture_next;
      speed_acc        <= speed_acc_next;
      spd_mode         <= spd_mode_next;
      lat_shift        <= lat_shift_next;
      lon_shift        <= lon_shift_next;
      stored_lat       <= stored_lat_next;
      stored_lon       <= stored_lon_next;
      stored_speed     <= stored_speed_next;
      overflow_seen    <= overflow_seen_next;
      if (!snap_valid || snap_ready) begin
        snap_valid <= snap_load;
      end
    end
    if (snap_load) begin
      snap <= snap_next;
    end
  end

  a_rmc_flag: assert property (@(posedge clk) disable iff (rst)
    line_is_rmc == (header_progress == HDR_MATCH))
    else $error("rmc flag out of step with header match");

  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (line_length == LW'(MAX_LINE)))
    else $error("overflow flagged below max line length");

  a_newline_clear: assert property (@(posedge clk) disable iff (rst)
    (consume && byte_q == CHAR_NL) |=> (line_length == '0 && field_number == 4'd0))
    else $error("line state not cleared at newline");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !snap_ready) |=> (snap_valid && $stable(snap)))
    else $error("snapshot changed while stalled");

endmodule

### design/nrmc_calendar.sv
// nrmc_calendar: splits captured time/date digits, adds the local offset
// with day/month/year rollover, and holds the result register. Depends on nrmc_pkg.
`timescale 1ns / 1ps

module nrmc_calendar import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       snap_valid,
  output logic       snap_ready,
  input  snap_t      snap,
  input  logic [4:0] utc_offset,
  output logic       res_valid,
  input  logic       res_ready,
  output res_word_t  res
);

  logic [20:0] t_grp, d_grp;
  logic [6:0]  t_hour, t_min, t_sec;
  logic [6:0]  d_day, d_mon, d_year;
  logic [4:0]  off;
  logic [6:0]  hour_sum, hour_wrap;
  logic        carry, mvalid;
  logic [6:0]  lim, dd, mm, yy;
  res_word_t   res_next;

  // two-digit groups from nibble-coded capture (digit+1, 0 = no digit)
  function automatic logic [20:0] split_groups(input logic [23:0] cap);
    logic       stop;
    logic [3:0] a, b;
    logic [20:0] r;
    stop = 1'b0;
    r    = '0;
    for (int g = 0; g < 3; g++) begin
      a = cap[23 - 8*g -: 4];
      b = cap[19 - 8*g -: 4];
      if (stop || a == 4'd0 || a > 4'd10) begin
        r[20 - 7*g -: 7] = 7'd0;
        stop = 1'b1;
      end else if (b == 4'd0 || b > 4'd10) begin
        r[20 - 7*g -: 7] = 7'(a - 4'd1);
        stop = 1'b1;
      end else begin
        r[20 - 7*g -: 7] = 7'(a - 4'd1) * 7'd10 + 7'(b - 4'd1);
      end
    end
    return r;
  endfunction

  assign snap_ready = !res_valid || res_ready;

  assign t_grp  = split_groups(snap.time_cap);
  assign d_grp  = split_groups(snap.date_cap);
  assign t_hour = t_grp[20:14];
  assign t_min  = t_grp[13:7];
  assign t_sec  = t_grp[6:0];
  assign d_day  = d_grp[20:14];
  assign d_mon  = d_grp[13:7];
  assign d_year = d_grp[6:0];

  assign off       = (utc_offset > HOUR_MAX) ? HOUR_MAX : utc_offset;
  assign hour_sum  = t_hour + 7'(off);
  assign carry     = hour_sum >= HOURS_PER_DAY;
  assign hour_wrap = carry ? hour_sum - HOURS_PER_DAY : hour_sum;
  assign mvalid    = (d_mon >= 7'd1) && (d_mon <= MONTHS_PER_YEAR);
  assign lim       = (d_mon == 7'd2 && d_year[1:0] == 2'd0) ? FEB_LEAP_DAYS
                                                            : month_len(4'(d_mon - 7'd1));

  always_comb begin
    dd = d_day;
    mm = d_mon;
    yy = d_year;
    if (carry) begin
      dd = d_day + 7'd1;
      if (mvalid && dd > lim) begin
        dd = 7'd1;
        mm = d_mon + 7'd1;
        if (mm > MONTHS_PER_YEAR) begin
          mm = 7'd1;
          yy = (d_year >= YEAR_MAX) ? 7'd0 : d_year + 7'd1;
        end
      end
    end
  end

  always_comb begin
    res_next.local_year       = yy;
    res_next.local_month      = mvalid ? mm[3:0] : 4'd0;
    res_next.local_day        = (dd > DAY_MAX) ? 5'd31 : dd[4:0];
    res_next.local_hour       = (hour_wrap > 7'(HOUR_MAX)) ? HOUR_MAX : hour_wrap[4:0];
    res_next.local_minute     = (t_min > MIN_SEC_MAX) ? 6'd59 : t_min[5:0];
    res_next.local_second     = (t_sec > MIN_SEC_MAX) ? 6'd59 : t_sec[5:0];
    res_next.speed_milliknots = snap.speed;
    res_next.latitude_text    = snap.lat;
    res_next.longitude_text   = snap.lon;
    res_next.line_truncated   = snap.trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (snap_ready) begin
      res_valid <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      res <= res_next;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.local_month <= 4'd12 && res.local_hour <= HOUR_MAX))
    else $error("result month or hour out of range");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && snap_ready) |=> res_valid)
    else $error("snapshot taken but no result");

endmodule

### design/nmea_rmc_parser_local_time_unit.sv
// Path: an accepted newline byte passes the byte register, then the parse/snapshot
// register, then the calendar result register, before its result is valid.
// Throughput: one byte per cycle; stalls only when the result register is held.
// Reset (rst, sync, active high): line state cleared, stored position text "0",
// stored speed 0, UTC offset 8. No clearing pass; ready right after reset.
`timescale 1ns / 1ps

module nmea_rmc_parser_local_time_unit import nrmc_pkg::*; #(
  parameter int MAX_LINE = 128
) (
  input logic       clk,
  input logic       rst,
  nrmc_rx_if.sink   rx,
  nrmc_res_if.source res,
  nrmc_cfg_if.sink  cfg
);

  logic [4:0] utc_offset;
  logic       snap_valid;
  logic       snap_ready;
  snap_t      snap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      utc_offset <= UTC_OFFSET_RESET;
    end else if (cfg.valid) begin
      utc_offset <= cfg.data.utc_offset_hours;
    end
  end

  nrmc_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (rx.valid),
    .byte_ready (rx.ready),
    .byte_in    (rx.data.rx_byte),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  nrmc_calendar u_calendar (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .utc_offset (utc_offset),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res        (res.data)
  );

endmodule
